// ===== src/tpot_pkg.sv =====
// Shared constants for the triangle pair overlap test core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpot_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_VERTS       = 3;
  localparam int NUM_PTS         = 2 * NUM_VERTS;
  localparam int NUM_AXES        = 2 * NUM_VERTS;

endpackage

`default_nettype wire

// ===== src/triangle_pair_overlap_test_core.sv =====
// Triangle pair overlap test by separating axes over the six triangle edges.
// A request accepted at the input passes through the vertex, projection and output registers
// in that order before it can be taken. Throughput is one request per cycle; the
// whole three-stage pipeline holds while out_stall is high and the output register is full.
// Synchronous active-low reset clears all valid flags; data registers are not reset.
// Depends on tpot_pkg, tpot_axis_proj, tpot_axis_test.
`default_nettype none

module triangle_pair_overlap_test_core
  import tpot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x0,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y0,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x1,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y1,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x2,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y2,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x0,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y0,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x1,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y1,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x2,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y2,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_overlapping
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  logic                          adv;
  logic                          v1_r;
  logic                          v2_r;
  logic                          out_valid_r;
  logic                          overlapping_r;
  logic                          overlapping_nxt;
  logic signed [COORD_WIDTH-1:0] vx_r [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] vy_r [NUM_PTS];
  logic signed [PW-1:0]          proj_nxt [NUM_AXES][NUM_PTS];
  logic signed [PW-1:0]          proj_r [NUM_AXES][NUM_PTS];
  logic [NUM_AXES-1:0]           sep;

  // The pipeline moves as a whole unless a finished result is held by the consumer.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0]       <= in_a_x0;
      vy_r[0]       <= in_a_y0;
      vx_r[1]       <= in_a_x1;
      vy_r[1]       <= in_a_y1;
      vx_r[2]       <= in_a_x2;
      vy_r[2]       <= in_a_y2;
      vx_r[3]       <= in_b_x0;
      vy_r[3]       <= in_b_y0;
      vx_r[4]       <= in_b_x1;
      vy_r[4]       <= in_b_y1;
      vx_r[5]       <= in_b_x2;
      vy_r[5]       <= in_b_y2;
      proj_r        <= proj_nxt;
      overlapping_r <= overlapping_nxt;
    end
  end

  for (genvar e = 0; e < NUM_AXES; e++) begin : g_axis
    localparam int BASE = (e / NUM_VERTS) * NUM_VERTS;
    localparam int IP   = BASE + (e % NUM_VERTS);
    localparam int IQ   = BASE + ((e % NUM_VERTS) + 1) % NUM_VERTS;

    tpot_axis_proj #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_proj (
      .p_x (vx_r[IP]),
      .p_y (vy_r[IP]),
      .q_x (vx_r[IQ]),
      .q_y (vy_r[IQ]),
      .vx  (vx_r),
      .vy  (vy_r),
      .proj(proj_nxt[e])
    );

    tpot_axis_test #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_test (
      .proj(proj_r[e]),
      .sep (sep[e])
    );
  end

  assign overlapping_nxt = ~|sep;

  assign out_valid       = out_valid_r;
  assign out_overlapping = overlapping_r;

endmodule

`default_nettype wire

// ===== src/tpot_axis_proj.sv =====
// Forms the perpendicular axis of one triangle edge and projects all six vertices onto it.
// Depends on tpot_pkg for the vertex count.
`default_nettype none

module tpot_axis_proj
  import tpot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PW = 2 * COORD_WIDTH + 2
) (
  input  wire logic signed [COORD_WIDTH-1:0] p_x,
  input  wire logic signed [COORD_WIDTH-1:0] p_y,
  input  wire logic signed [COORD_WIDTH-1:0] q_x,
  input  wire logic signed [COORD_WIDTH-1:0] q_y,
  input  wire logic signed [COORD_WIDTH-1:0] vx [NUM_PTS],
  input  wire logic signed [COORD_WIDTH-1:0] vy [NUM_PTS],
  output logic signed [PW-1:0]               proj [NUM_PTS]
);

  localparam int MW = 2 * COORD_WIDTH + 1;

  logic signed [COORD_WIDTH:0] ax;
  logic signed [COORD_WIDTH:0] ay;

  // The edge vector is p - q; its perpendicular is (q_y - p_y, p_x - q_x).
  assign ax = (COORD_WIDTH + 1)'(q_y) - (COORD_WIDTH + 1)'(p_y);
  assign ay = (COORD_WIDTH + 1)'(p_x) - (COORD_WIDTH + 1)'(q_x);

  for (genvar k = 0; k < NUM_PTS; k++) begin : g_pt
    logic signed [MW-1:0] m_x;
    logic signed [MW-1:0] m_y;

    assign m_x     = MW'(ax) * MW'(vx[k]);
    assign m_y     = MW'(ay) * MW'(vy[k]);
    assign proj[k] = PW'(m_x) + PW'(m_y);
  end

endmodule

`default_nettype wire

// ===== src/tpot_axis_test.sv =====
// Takes the six projections on one axis and decides whether that axis separates the triangles.
// Depends on tpot_pkg for the vertex count.
`default_nettype none

module tpot_axis_test
  import tpot_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int PW = 2 * COORD_WIDTH + 2
) (
  input  wire logic signed [PW-1:0] proj [NUM_PTS],
  output logic                      sep
);

  logic signed [PW-1:0] a_lo;
  logic signed [PW-1:0] a_hi;
  logic signed [PW-1:0] b_lo;
  logic signed [PW-1:0] b_hi;

  always_comb begin
    a_lo = proj[0];
    a_hi = proj[0];
    b_lo = proj[NUM_VERTS];
    b_hi = proj[NUM_VERTS];
    for (int k = 1; k < NUM_VERTS; k++) begin
      if (proj[k] < a_lo) a_lo = proj[k];
      if (proj[k] > a_hi) a_hi = proj[k];
      if (proj[NUM_VERTS + k] < b_lo) b_lo = proj[NUM_VERTS + k];
      if (proj[NUM_VERTS + k] > b_hi) b_hi = proj[NUM_VERTS + k];
    end
  end

  // Touching intervals do not separate.
  assign sep = (a_lo > b_hi) || (b_lo > a_hi);

endmodule

`default_nettype wire

// ===== tb/triangle_pair_overlap_test_core_tb.sv =====
// Testbench for triangle_pair_overlap_test_core: directed and random triangle pairs, checked
// against a separating-axis predictor, with random idling on both sides and a long output hold.
// Depends on tpot_pkg and the triangle_pair_overlap_test_core RTL.
`default_nettype none

module triangle_pair_overlap_test_core_tb
  import tpot_pkg::*;
;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t [NUM_VERTS-1:0] ax;
    coord_t [NUM_VERTS-1:0] ay;
    coord_t [NUM_VERTS-1:0] bx;
    coord_t [NUM_VERTS-1:0] by;
  } tri_pair_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tri_pair_t drv_pair = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      out_overlapping;

  bit   overlap_expect_q[$];
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_tag = 0;
  int   hold_tag_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  triangle_pair_overlap_test_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_a_x0         (drv_pair.ax[0]),
    .in_a_y0         (drv_pair.ay[0]),
    .in_a_x1         (drv_pair.ax[1]),
    .in_a_y1         (drv_pair.ay[1]),
    .in_a_x2         (drv_pair.ax[2]),
    .in_a_y2         (drv_pair.ay[2]),
    .in_b_x0         (drv_pair.bx[0]),
    .in_b_y0         (drv_pair.by[0]),
    .in_b_x1         (drv_pair.bx[1]),
    .in_b_y1         (drv_pair.by[1]),
    .in_b_x2         (drv_pair.bx[2]),
    .in_b_y2         (drv_pair.by[2]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_overlapping (out_overlapping)
  );

  always #4 clk = ~clk;

  // The pair overlaps unless the perpendicular of an edge of either triangle separates the
  // projected vertex intervals strictly.
  function automatic bit overlap_expected(input tri_pair_t p);
    longint px[NUM_PTS];
    longint py[NUM_PTS];
    longint nx, ny, dot;
    longint a_lo, a_hi, b_lo, b_hi;
    int     base, i, j;
    for (int k = 0; k < NUM_VERTS; k++) begin
      px[k]             = longint'($signed(p.ax[k]));
      py[k]             = longint'($signed(p.ay[k]));
      px[k + NUM_VERTS] = longint'($signed(p.bx[k]));
      py[k + NUM_VERTS] = longint'($signed(p.by[k]));
    end
    for (int e = 0; e < NUM_AXES; e++) begin
      base = (e / NUM_VERTS) * NUM_VERTS;
      i    = base + e % NUM_VERTS;
      j    = base + (e + 1) % NUM_VERTS;
      nx   = py[j] - py[i];
      ny   = px[i] - px[j];
      for (int k = 0; k < NUM_PTS; k++) begin
        dot = nx * px[k] + ny * py[k];
        if (k == 0) begin
          a_lo = dot;
          a_hi = dot;
        end else if (k < NUM_VERTS) begin
          if (dot < a_lo) a_lo = dot;
          if (dot > a_hi) a_hi = dot;
        end else if (k == NUM_VERTS) begin
          b_lo = dot;
          b_hi = dot;
        end else begin
          if (dot < b_lo) b_lo = dot;
          if (dot > b_hi) b_hi = dot;
        end
      end
      if (a_lo > b_hi || b_lo > a_hi) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic tri_pair_t make_pair(input int a[6], input int b[6]);
    tri_pair_t p;
    for (int k = 0; k < NUM_VERTS; k++) begin
      p.ax[k] = coord_t'(a[2 * k]);
      p.ay[k] = coord_t'(a[2 * k + 1]);
      p.bx[k] = coord_t'(b[2 * k]);
      p.by[k] = coord_t'(b[2 * k + 1]);
    end
    return p;
  endfunction

  task automatic send_pair(input tri_pair_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    drv_pair <= p;
    do @(posedge clk); while (in_stall);
    overlap_expect_q.push_back(overlap_expected(p));
  endtask

  task automatic test_extremes();
    send_pair(make_pair('{-32768, -32768, 32767, -32768, -32768, 32767},
                        '{32767, 32767, 32767, 32767, 32767, 32767}));
    send_pair(make_pair('{-32768, -32768, 32767, -32768, -32768, 32767},
                        '{-32768, -32768, 32767, -32768, -32768, 32767}));
    send_pair(make_pair('{32767, 32767, -32768, 32767, 32767, -32768},
                        '{-32768, -32768, -32768, -32768, -32768, -32768}));
    send_pair(make_pair('{-32768, 32767, 32767, -32768, -32768, -32768},
                        '{32767, 32767, -32768, 32767, 32767, -32768}));
    send_pair(make_pair('{21845, -21846, -21846, 21845, 21845, 21845},
                        '{-21846, -21846, 21845, -21846, -1, 0}));
    send_pair(make_pair('{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}));
    send_pair(make_pair('{-1, -1, -1, -1, -1, -1}, '{0, 0, 0, 0, 0, 0}));
  endtask

  task automatic test_touching();
    send_pair(make_pair('{0, 0, 10, 0, 0, 10}, '{10, 0, 20, 0, 10, 10}));
    send_pair(make_pair('{0, 0, 10, 0, 0, 10}, '{10, 0, 0, 10, 10, 10}));
    send_pair(make_pair('{0, 0, 10, 0, 0, 10}, '{11, 0, 21, 0, 11, 10}));
    send_pair(make_pair('{0, 0, 10, 0, 0, 10}, '{6, 6, 16, 6, 6, 16}));
    send_pair(make_pair('{0, 0, 10, 0, 0, 10}, '{5, 5, 15, 5, 5, 15}));
    send_pair(make_pair('{0, 0, 100, 0, 0, 100}, '{10, 10, 20, 10, 10, 20}));
    send_pair(make_pair('{10, 10, 20, 10, 10, 20}, '{0, 0, 100, 0, 0, 100}));
  endtask

  task automatic test_degenerate();
    send_pair(make_pair('{0, 0, 0, 0, 5, 5}, '{5, 5, 9, 1, 9, 9}));
    send_pair(make_pair('{0, 0, 0, 0, 5, 5}, '{6, 5, 9, 1, 9, 9}));
    send_pair(make_pair('{0, 0, 4, 4, 8, 8}, '{0, 8, 8, 0, 8, 8}));
    send_pair(make_pair('{0, 0, 4, 4, 8, 8}, '{1, 0, 9, 8, 9, 0}));
    send_pair(make_pair('{3, 3, 3, 3, 3, 3}, '{0, 0, 6, 0, 0, 6}));
    send_pair(make_pair('{3, 4, 3, 4, 3, 4}, '{0, 0, 6, 0, 0, 6}));
    send_pair(make_pair('{2, 2, 2, 2, 2, 2}, '{2, 2, 2, 2, 2, 2}));
  endtask

  function automatic int rand_coord_extreme();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic tri_pair_t rand_pair();
    tri_pair_t p;
    int        a[6];
    int        b[6];
    int        cx, cy, spread;
    case ($urandom_range(3))
      0: begin
        p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return p;
      end
      3: begin
        for (int k = 0; k < 6; k++) begin
          a[k] = rand_coord_extreme();
          b[k] = rand_coord_extreme();
        end
      end
      default: begin
        spread = ($urandom_range(3) == 0) ? 4000 : 16;
        cx = int'($urandom_range(64000 - 2 * spread)) - 32000 + spread;
        cy = int'($urandom_range(64000 - 2 * spread)) - 32000 + spread;
        for (int k = 0; k < 6; k += 2) begin
          a[k]     = cx + int'($urandom_range(2 * spread)) - spread;
          a[k + 1] = cy + int'($urandom_range(2 * spread)) - spread;
          b[k]     = cx + int'($urandom_range(2 * spread)) - spread;
          b[k + 1] = cy + int'($urandom_range(2 * spread)) - spread;
        end
        if ($urandom_range(1) == 1) begin
          b[0] = a[2];
          b[1] = a[3];
          if ($urandom_range(1) == 1) begin
            b[2] = a[4];
            b[3] = a[5];
          end
        end
      end
    endcase
    return make_pair(a, b);
  endfunction

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_pair(rand_pair());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_tag <= hold_tag + 1;
    for (int n = 0; n < 40; n++) send_pair(rand_pair());
  endtask

  always @(posedge clk) begin
    if (hold_tag != hold_tag_seen) begin
      hold_tag_seen <= hold_tag;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (overlap_expect_q.size() == 0) begin
        $error("overlapping: no request pending, got %0b", out_overlapping);
        error_count++;
      end else if (out_overlapping !== overlap_expect_q[0]) begin
        $error("overlapping: expected %0b, got %0b", overlap_expect_q[0], out_overlapping);
        error_count++;
        void'(overlap_expect_q.pop_front());
      end else begin
        void'(overlap_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 68;
    test_extremes();
    test_touching();
    test_degenerate();
    test_random(580);
    test_backpressure();
    send_idle_pct = 68;
    recv_idle_pct = 27;
    test_random(580);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(550);
    in_valid <= 1'b0;
    while (overlap_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== triangle_pair_overlap_test_core.f =====
src/tpot_pkg.sv
src/tpot_axis_proj.sv
src/tpot_axis_test.sv
src/triangle_pair_overlap_test_core.sv
tb/triangle_pair_overlap_test_core_tb.sv
